### rtl/fpsq_pkg.sv
// ----------------------------------------------------------------------------
// fpsq_pkg
// Shared types and codes for the flap module poll sequencer: channel words,
// the job record passed from front to back, and reply classification codes.
// ----------------------------------------------------------------------------
package fpsq_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_LAST_MODULE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONTENT_EN  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_OP     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_STATE_OP    = 3'd4;

    localparam logic [7:0]  LAST_MODULE_RESET = 8'd1;
    localparam logic [15:0] TIMEOUT_RESET     = 16'd100;

    localparam logic [7:0] REPLY_INVALID  = 8'h10;
    localparam logic [7:0] REPLY_CHAR_MIN = 8'h20;
    localparam logic [7:0] LO_NIBBLE_SET  = 8'h0F;
    localparam logic [7:0] HI_NIBBLE_SET  = 8'hF0;
    localparam logic [7:0] CHAR_FIRST     = 8'hAF;
    localparam logic [7:0] CHAR_UNKNOWN   = 8'hCF;
    localparam logic [7:0] CHAR_KNOWN     = 8'h8F;
    localparam logic [7:0] MOTOR_AT_POS   = 8'hF0;
    localparam logic [7:0] MOTOR_MOVING   = 8'hFF;
    localparam logic [7:0] MOTOR_SUPPLY   = 8'hF4;
    localparam logic [7:0] MOTOR_FAIL     = 8'hF2;

    localparam logic [1:0] CC_TIMEOUT   = 2'd0;
    localparam logic [1:0] CC_INVALID   = 2'd1;
    localparam logic [1:0] CC_VALID     = 2'd2;
    localparam logic [1:0] CC_UNDEFINED = 2'd3;

    localparam logic [1:0] CS_FIRST   = 2'd0;
    localparam logic [1:0] CS_UNKNOWN = 2'd1;
    localparam logic [1:0] CS_KNOWN   = 2'd2;
    localparam logic [1:0] CS_OTHER   = 2'd3;

    localparam logic [2:0] MC_AT_POS = 3'd0;
    localparam logic [2:0] MC_MOVING = 3'd1;
    localparam logic [2:0] MC_SUPPLY = 3'd2;
    localparam logic [2:0] MC_FAIL   = 3'd3;
    localparam logic [2:0] MC_OTHER  = 3'd4;

    typedef enum logic [1:0] {
        KIND_TX      = 2'd0,
        KIND_CONTENT = 2'd1,
        KIND_STATE   = 2'd2,
        KIND_DONE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STEP_ENTRY    = 2'd0,
        STEP_DONE     = 2'd1,
        STEP_OPCODE   = 2'd2,
        STEP_POSITION = 2'd3
    } step_t;

    typedef struct packed {
        logic       func;
        logic       rx_valid;
        logic [7:0] rx_byte;
    } poll_in_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic [7:0] module_index;
        logic [1:0] char_class;
        logic [2:0] motor_class;
        logic       any_rolling;
        logic       last;
    } poll_out_t;

    typedef struct packed {
        logic       entry_en;
        kind_t      entry_kind;
        logic [7:0] entry_data;
        logic [1:0] entry_char;
        logic [2:0] entry_motor;
        logic [7:0] index;
        logic       done_en;
        logic       done_roll;
        logic [7:0] req_op;
        logic [7:0] req_pos;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

### rtl/fpsq_front.sv
// ----------------------------------------------------------------------------
// fpsq_front
// Accepts input words, tracks sweep position and reply timeout, classifies
// replies and pushes one job per result-bearing word into the queue.
// ----------------------------------------------------------------------------
module fpsq_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  fpsq_pkg::poll_in_t               in_word,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fpsq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fpsq_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  fpsq_pkg::q_status_t              q_status,
    output logic                             push,
    output fpsq_pkg::job_t                   push_job
);
    import fpsq_pkg::*;

    logic [7:0]  last_module_reg;
    logic [15:0] timeout_reg;
    logic        content_en_reg;
    logic [7:0]  read_op_reg;
    logic [7:0]  state_op_reg;

    logic        sweep_content_reg, sweep_content_next;
    logic [7:0]  pos_reg, pos_next;
    logic        awaiting_reg, awaiting_next;
    logic [15:0] wait_reg, wait_next;
    logic        rolling_reg, rolling_next;

    logic        accept;
    logic        have_reply;
    logic [7:0]  reply;
    logic [1:0]  content_cc;
    logic [1:0]  state_cc;
    logic [2:0]  state_mc;
    logic        next_content;
    job_t        job;
    logic        job_valid;

    assign in_ready  = !q_status.full;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign push      = job_valid;
    assign push_job  = job;

    always_comb
    begin
        if (reply == 8'h00)
            content_cc = CC_TIMEOUT;
        else if (reply == REPLY_INVALID)
            content_cc = CC_INVALID;
        else if (reply >= REPLY_CHAR_MIN)
            content_cc = CC_VALID;
        else
            content_cc = CC_UNDEFINED;
    end

    always_comb
    begin
        case (reply | LO_NIBBLE_SET)
            CHAR_FIRST:   state_cc = CS_FIRST;
            CHAR_UNKNOWN: state_cc = CS_UNKNOWN;
            CHAR_KNOWN:   state_cc = CS_KNOWN;
            default:      state_cc = CS_OTHER;
        endcase
        case (reply | HI_NIBBLE_SET)
            MOTOR_AT_POS: state_mc = MC_AT_POS;
            MOTOR_MOVING: state_mc = MC_MOVING;
            MOTOR_SUPPLY: state_mc = MC_SUPPLY;
            MOTOR_FAIL:   state_mc = MC_FAIL;
            default:      state_mc = MC_OTHER;
        endcase
    end

    always_comb
    begin
        sweep_content_next = sweep_content_reg;
        pos_next           = pos_reg;
        awaiting_next      = awaiting_reg;
        wait_next          = wait_reg;
        rolling_next       = rolling_reg;
        have_reply         = 1'b0;
        reply              = 8'h00;
        next_content       = 1'b0;
        job                = '0;
        job_valid          = 1'b0;

        if (accept)
        begin
            if (in_word.func)
            begin
                job_valid          = 1'b1;
                job.req_op         = state_op_reg;
                job.req_pos        = 8'd1;
                sweep_content_next = 1'b0;
                pos_next           = 8'd1;
                awaiting_next      = 1'b1;
                wait_next          = '0;
                rolling_next       = 1'b0;
            end
            else if (awaiting_reg)
            begin
                if (in_word.rx_valid)
                begin
                    have_reply = 1'b1;
                    reply      = in_word.rx_byte;
                end
                else if (wait_reg >= timeout_reg)
                begin
                    have_reply = 1'b1;
                end
                else
                begin
                    wait_next = wait_reg + 16'd1;
                end
            end
        end

        if (have_reply)
        begin
            job_valid    = 1'b1;
            job.entry_en = 1'b1;
            job.index    = pos_reg;
            if (sweep_content_reg)
            begin
                job.entry_kind = KIND_CONTENT;
                job.entry_char = content_cc;
                job.entry_data = (content_cc == CC_VALID) ? reply : 8'h00;
            end
            else
            begin
                job.entry_kind  = KIND_STATE;
                job.entry_char  = state_cc;
                job.entry_motor = state_mc;
                if (state_mc == MC_MOVING)
                    rolling_next = 1'b1;
            end

            if (pos_reg < last_module_reg)
            begin
                next_content = sweep_content_reg;
                job.req_pos  = pos_reg + 8'd1;
            end
            else
            begin
                job.done_en = 1'b1;
                job.req_pos = 8'd1;
                if (sweep_content_reg)
                begin
                    next_content = 1'b0;
                end
                else
                begin
                    job.done_roll = rolling_next;
                    rolling_next  = 1'b0;
                    next_content  = content_en_reg;
                end
            end
            job.req_op         = next_content ? read_op_reg : state_op_reg;
            sweep_content_next = next_content;
            pos_next           = job.req_pos;
            wait_next          = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_module_reg <= LAST_MODULE_RESET;
            timeout_reg     <= TIMEOUT_RESET;
            content_en_reg  <= 1'b1;
            read_op_reg     <= 8'h00;
            state_op_reg    <= 8'h00;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LAST_MODULE: last_module_reg <= cfg_data[7:0];
                CFG_TIMEOUT:     timeout_reg     <= cfg_data[15:0];
                CFG_CONTENT_EN:  content_en_reg  <= cfg_data[0];
                CFG_READ_OP:     read_op_reg     <= cfg_data[7:0];
                CFG_STATE_OP:    state_op_reg    <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_content_reg <= 1'b0;
            pos_reg           <= 8'd1;
            awaiting_reg      <= 1'b0;
            wait_reg          <= '0;
            rolling_reg       <= 1'b0;
        end
        else
        begin
            sweep_content_reg <= sweep_content_next;
            pos_reg           <= pos_next;
            awaiting_reg      <= awaiting_next;
            wait_reg          <= wait_next;
            rolling_reg       <= rolling_next;
        end
    end

endmodule

### rtl/fpsq_queue.sv
// ----------------------------------------------------------------------------
// fpsq_queue
// Short FIFO of job records between the front and back ends.
// ----------------------------------------------------------------------------
module fpsq_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  fpsq_pkg::job_t      push_job,
    input  logic                pop,
    output fpsq_pkg::job_t      head,
    output fpsq_pkg::q_status_t status
);
    import fpsq_pkg::*;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/fpsq_back.sv
// ----------------------------------------------------------------------------
// fpsq_back
// Expands each job into its result words (entry, sweep done, opcode byte,
// position byte) and drives them through a registered output stage.
// ----------------------------------------------------------------------------
module fpsq_back (
    input  logic                clk,
    input  logic                rst_n,
    input  fpsq_pkg::job_t      head,
    input  fpsq_pkg::q_status_t q_status,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output fpsq_pkg::poll_out_t out_word
);
    import fpsq_pkg::*;

    job_t      cur_job_reg, cur_job_next;
    logic      cur_valid_reg, cur_valid_next;
    step_t     step_reg, step_next;
    logic      out_valid_reg, out_valid_next;
    poll_out_t out_word_reg, out_word_next;

    job_t      sel_job;
    step_t     sel_step;
    step_t     after_step;
    logic      have;
    logic      load_ok;
    logic      emit;

    assign load_ok   = !out_valid_reg || out_ready;
    assign have      = cur_valid_reg || !q_status.empty;
    assign emit      = load_ok && have;
    assign pop       = load_ok && !cur_valid_reg && !q_status.empty;
    assign sel_job   = cur_valid_reg ? cur_job_reg : head;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_comb
    begin
        if (cur_valid_reg)
            sel_step = step_reg;
        else if (head.entry_en)
            sel_step = STEP_ENTRY;
        else if (head.done_en)
            sel_step = STEP_DONE;
        else
            sel_step = STEP_OPCODE;
    end

    // next step sequencing
    always_comb
    begin
        case (sel_step)
            STEP_ENTRY:    after_step = sel_job.done_en ? STEP_DONE : STEP_OPCODE;
            STEP_DONE:     after_step = STEP_OPCODE;
            STEP_OPCODE:   after_step = STEP_POSITION;
            STEP_POSITION: after_step = STEP_ENTRY;
            default:       after_step = STEP_ENTRY;
        endcase

        cur_job_next   = cur_job_reg;
        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        if (emit)
        begin
            cur_job_next   = sel_job;
            cur_valid_next = (sel_step != STEP_POSITION);
            step_next      = after_step;
        end
    end

    // result word for the selected step
    always_comb
    begin
        out_word_next = '0;
        case (sel_step)
            STEP_ENTRY:
            begin
                out_word_next.kind         = sel_job.entry_kind;
                out_word_next.data_byte    = sel_job.entry_data;
                out_word_next.module_index = sel_job.index;
                out_word_next.char_class   = sel_job.entry_char;
                out_word_next.motor_class  = sel_job.entry_motor;
            end
            STEP_DONE:
            begin
                out_word_next.kind         = KIND_DONE;
                out_word_next.module_index = sel_job.index;
                out_word_next.any_rolling  = sel_job.done_roll;
            end
            STEP_OPCODE:
            begin
                out_word_next.kind         = KIND_TX;
                out_word_next.data_byte    = sel_job.req_op;
                out_word_next.module_index = sel_job.req_pos;
            end
            STEP_POSITION:
            begin
                out_word_next.kind         = KIND_TX;
                out_word_next.data_byte    = sel_job.req_pos;
                out_word_next.module_index = sel_job.req_pos;
                out_word_next.last         = 1'b1;
            end
            default: ;
        endcase
        out_valid_next = load_ok ? have : out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_word_reg <= out_word_next;
        cur_job_reg <= cur_job_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= STEP_ENTRY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/flap_module_poll_sequencer_core.sv
// ----------------------------------------------------------------------------
// flap_module_poll_sequencer_core
// The first result word of an item is queued on the edge that accepts it and
// leaves through the registered output stage. Throughput: one input word per
// clock into a four-deep job queue while not full; the output stage sends one
// word per clock while out_ready holds, and an item yields two to four words.
// Reset: idle until a start word, registers at their defaults, queue empty.
// ----------------------------------------------------------------------------
module flap_module_poll_sequencer_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  fpsq_pkg::poll_in_t               in_word,
    output logic                             out_valid,
    input  logic                             out_ready,
    output fpsq_pkg::poll_out_t              out_word,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fpsq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fpsq_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fpsq_pkg::*;

    logic      q_push;
    job_t      q_push_job;
    logic      q_pop;
    job_t      q_head;
    q_status_t q_status;

    fpsq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .push      (q_push),
        .push_job  (q_push_job)
    );

    fpsq_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_push_job),
        .pop      (q_pop),
        .head     (q_head),
        .status   (q_status)
    );

    fpsq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_status  (q_status),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("queue popped while empty");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("queue pushed while full");

    a_done_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.kind == KIND_DONE) |-> !out_word.last)
        else $error("sweep done word closes an item");

    a_rolling_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.any_rolling) |-> (out_word.kind == KIND_DONE))
        else $error("rolling flag outside a sweep done word");

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the flap module poll sequencer core. A queue-fed
// driver sends ticks, start words and reply bytes in random bursts while the
// receiver stalls on a changing pattern. Every accepted input word is run
// through a behavioral copy of the sequencer, and each output word is checked
// field by field against the oldest predicted word. Register settings change
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
    import fpsq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    poll_in_t               in_word = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    poll_out_t              out_word;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    poll_in_t  poll_pending[$];
    poll_out_t expected_results[$];

    int  words_queued = 0;
    int  words_taken = 0;
    int  mismatches = 0;
    int  cycle_count = 0;
    int  burst_left = 1;
    int  gap_left = 0;
    int  stall_cnt = 0;
    int  stall_mode = 0;
    bit  in_taken = 1'b0;
    bit  cfg_taken = 1'b0;

    // sequencer copy: registers and poll state
    logic [7:0]  reg_last_module = LAST_MODULE_RESET;
    logic [15:0] reg_timeout = TIMEOUT_RESET;
    logic        reg_content_en = 1'b1;
    logic [7:0]  reg_read_op = 8'h00;
    logic [7:0]  reg_state_op = 8'h00;
    logic        sweep_content = 1'b0;
    logic [7:0]  poll_pos = 8'd1;
    logic        polling = 1'b0;
    logic [15:0] idle_ticks = 16'd0;
    logic        rolling_flag = 1'b0;

    flap_module_poll_sequencer_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic push_word(input kind_t k, input logic [7:0] data, input logic [7:0] idx,
                             input logic [1:0] cc, input logic [2:0] mc, input logic roll);
        poll_out_t w;
        w.kind = k;
        w.data_byte = data;
        w.module_index = idx;
        w.char_class = cc;
        w.motor_class = mc;
        w.any_rolling = roll;
        w.last = 1'b0;
        expected_results.insert(expected_results.size(), w);
    endtask

    task automatic request_module(input logic content, input logic [7:0] pos);
        push_word(KIND_TX, content ? reg_read_op : reg_state_op, pos, 2'd0, 3'd0, 1'b0);
        push_word(KIND_TX, pos, pos, 2'd0, 3'd0, 1'b0);
        sweep_content = content;
        poll_pos = pos;
        polling = 1'b1;
        idle_ticks = 16'd0;
    endtask

    task automatic predict_poll(input poll_in_t w);
        int         depth_before;
        logic       have_reply;
        logic       next_content;
        logic [7:0] reply;
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] data;
        logic [1:0] cc;
        logic [2:0] mc;
        poll_out_t  tail;
        depth_before = expected_results.size();
        have_reply = 1'b0;
        reply = 8'h00;
        if (w.func)
        begin
            rolling_flag = 1'b0;
            request_module(1'b0, 8'd1);
        end
        else if (polling)
        begin
            if (w.rx_valid)
            begin
                reply = w.rx_byte;
                have_reply = 1'b1;
            end
            else if (idle_ticks >= reg_timeout)
            begin
                have_reply = 1'b1;
            end
            else
            begin
                idle_ticks++;
            end
        end
        if (have_reply)
        begin
            if (sweep_content)
            begin
                data = 8'h00;
                if (reply == 8'h00)
                    cc = CC_TIMEOUT;
                else if (reply == REPLY_INVALID)
                    cc = CC_INVALID;
                else if (reply >= REPLY_CHAR_MIN)
                begin
                    cc = CC_VALID;
                    data = reply;
                end
                else
                    cc = CC_UNDEFINED;
                push_word(KIND_CONTENT, data, poll_pos, cc, MC_AT_POS, 1'b0);
            end
            else
            begin
                hi = reply | LO_NIBBLE_SET;
                lo = reply | HI_NIBBLE_SET;
                if (hi == CHAR_FIRST)
                    cc = CS_FIRST;
                else if (hi == CHAR_UNKNOWN)
                    cc = CS_UNKNOWN;
                else if (hi == CHAR_KNOWN)
                    cc = CS_KNOWN;
                else
                    cc = CS_OTHER;
                if (lo == MOTOR_AT_POS)
                    mc = MC_AT_POS;
                else if (lo == MOTOR_MOVING)
                begin
                    mc = MC_MOVING;
                    rolling_flag = 1'b1;
                end
                else if (lo == MOTOR_SUPPLY)
                    mc = MC_SUPPLY;
                else if (lo == MOTOR_FAIL)
                    mc = MC_FAIL;
                else
                    mc = MC_OTHER;
                push_word(KIND_STATE, 8'h00, poll_pos, cc, mc, 1'b0);
            end
            if (poll_pos < reg_last_module)
            begin
                request_module(sweep_content, poll_pos + 8'd1);
            end
            else
            begin
                if (sweep_content)
                begin
                    push_word(KIND_DONE, 8'h00, poll_pos, 2'd0, 3'd0, 1'b0);
                    next_content = 1'b0;
                end
                else
                begin
                    push_word(KIND_DONE, 8'h00, poll_pos, 2'd0, 3'd0, rolling_flag);
                    rolling_flag = 1'b0;
                    next_content = reg_content_en;
                end
                request_module(next_content, 8'd1);
            end
        end
        if (expected_results.size() > depth_before)
        begin
            tail = expected_results.pop_back();
            tail.last = 1'b1;
            expected_results.insert(expected_results.size(), tail);
        end
    endtask

    task automatic apply_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_LAST_MODULE: reg_last_module = val[7:0];
            CFG_TIMEOUT:     reg_timeout = val;
            CFG_CONTENT_EN:  reg_content_en = val[0];
            CFG_READ_OP:     reg_read_op = val[7:0];
            CFG_STATE_OP:    reg_state_op = val[7:0];
            default:         ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            mismatches++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    task automatic check_result(input poll_out_t got);
        poll_out_t want;
        if (expected_results.size() == 0)
        begin
            mismatches++;
            $error("unexpected word: kind %0d module %0d", got.kind, got.module_index);
        end
        else
        begin
            want = expected_results.pop_front();
            check_field("kind", want.kind, got.kind);
            check_field("data_byte", want.data_byte, got.data_byte);
            check_field("module_index", want.module_index, got.module_index);
            check_field("char_class", want.char_class, got.char_class);
            check_field("motor_class", want.motor_class, got.motor_class);
            check_field("any_rolling", want.any_rolling, got.any_rolling);
            check_field("last", want.last, got.last);
        end
    endtask

    always @(posedge clk)
    begin
        in_taken = rst_n && in_valid && in_ready;
        cfg_taken = rst_n && cfg_valid && cfg_ready;
        if (rst_n && out_valid && out_ready)
            check_result(out_word);
        if (cfg_taken)
            apply_reg(cfg_index, cfg_data);
        if (in_taken)
        begin
            predict_poll(in_word);
            words_taken++;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (poll_pending.size() > 0)
            begin
                in_word <= poll_pending.pop_front();
                in_valid <= 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        stall_cnt++;
        if (stall_cnt % 48 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= (stall_cnt[1:0] == 2'd0);
            default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic queue_word(input logic func, input logic rx_valid, input logic [7:0] rx_byte);
        poll_in_t w;
        w.func = func;
        w.rx_valid = rx_valid;
        w.rx_byte = rx_byte;
        poll_pending.insert(poll_pending.size(), w);
        words_queued++;
    endtask

    function automatic logic [7:0] pick_reply();
        logic [3:0] hi;
        logic [3:0] lo;
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 255));
            1:
            begin
                case ($urandom_range(0, 4))
                    0:       return 8'h00;
                    1:       return REPLY_INVALID;
                    2:       return 8'h1F;
                    3:       return REPLY_CHAR_MIN;
                    default: return 8'hFF;
                endcase
            end
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       hi = 4'hA;
                    1:       hi = 4'hC;
                    2:       hi = 4'h8;
                    default: hi = 4'($urandom_range(0, 15));
                endcase
                case ($urandom_range(0, 4))
                    0:       lo = 4'h0;
                    1:       lo = 4'hF;
                    2:       lo = 4'h4;
                    3:       lo = 4'h2;
                    default: lo = 4'($urandom_range(0, 15));
                endcase
                return {hi, lo};
            end
        endcase
    endfunction

    task automatic random_traffic(input int budget, input int timeout);
        int start;
        int empties;
        start = words_queued;
        while (words_queued - start < budget)
        begin
            case ($urandom_range(0, 19))
                0:
                begin
                    queue_word(1'b1, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                end
                1:
                begin
                    queue_word(1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                end
                default:
                begin
                    empties = $urandom_range(0, 2);
                    if (timeout <= 6 && $urandom_range(0, 2) == 0)
                        empties = timeout + $urandom_range(0, 1);
                    repeat (empties)
                        queue_word(1'b0, 1'b0, 8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 7) != 0)
                    begin
                        queue_word(1'b0, 1'b1, pick_reply());
                    end
                end
            endcase
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_settings(input logic [7:0] last_mod, input logic [15:0] timeout,
                                  input logic content_en, input logic [7:0] read_op,
                                  input logic [7:0] state_op);
        write_reg(CFG_LAST_MODULE, {8'h00, last_mod});
        write_reg(CFG_TIMEOUT, timeout);
        write_reg(CFG_CONTENT_EN, {15'h0000, content_en});
        write_reg(CFG_READ_OP, {8'h00, read_op});
        write_reg(CFG_STATE_OP, {8'h00, state_op});
    endtask

    task automatic drain();
        while (words_taken != words_queued || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // default settings: idle ticks, then every reply class
        queue_word(1'b0, 1'b1, 8'hFF);
        queue_word(1'b0, 1'b0, 8'h00);
        queue_word(1'b1, 1'b0, 8'h00);
        queue_word(1'b0, 1'b0, 8'h5A);
        queue_word(1'b0, 1'b1, 8'hA0);
        queue_word(1'b0, 1'b1, 8'h00);
        queue_word(1'b0, 1'b1, 8'hCF);
        queue_word(1'b0, 1'b1, REPLY_INVALID);
        queue_word(1'b0, 1'b1, 8'h84);
        queue_word(1'b0, 1'b1, REPLY_CHAR_MIN);
        queue_word(1'b0, 1'b1, 8'h32);
        queue_word(1'b0, 1'b1, 8'h1F);
        queue_word(1'b0, 1'b1, 8'h5B);
        queue_word(1'b0, 1'b1, 8'hFF);
        queue_word(1'b1, 1'b1, 8'h8F);
        queue_word(1'b0, 1'b1, 8'hAF);
        drain();

        // short timeout: byte at the limit wins, then a real timeout
        write_settings(8'd3, 16'd2, 1'b1, 8'hA5, 8'h5A);
        queue_word(1'b1, 1'b0, 8'h00);
        queue_word(1'b0, 1'b0, 8'h11);
        queue_word(1'b0, 1'b0, 8'h22);
        queue_word(1'b0, 1'b1, 8'hFF);
        repeat (3)
            queue_word(1'b0, 1'b0, 8'($urandom_range(0, 255)));
        random_traffic(60, 2);
        drain();

        write_settings(8'd0, 16'd1, 1'b0, 8'hFF, 8'h00);
        random_traffic(40, 1);
        drain();

        write_settings(8'd255, 16'd65535, 1'b1, 8'h00, 8'hFF);
        random_traffic(45, 65535);
        drain();

        // lower the module count below the current position
        write_settings(8'd2, 16'd3, 1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        random_traffic(65, 3);
        drain();

        write_settings(8'd1, 16'd5, 1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        random_traffic(75, 5);
        drain();

        if (mismatches == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
